// ----- rtl/int8_dot_product_unit_defines.svh -----
// ----------------------------------------------------------------------------
// int8_dot_product_unit_defines.svh
// Assertion macros used by the checker file of the dot-product unit.
// ----------------------------------------------------------------------------
`ifndef INT8_DOT_PRODUCT_UNIT_DEFINES_SVH
`define INT8_DOT_PRODUCT_UNIT_DEFINES_SVH

// Same-cycle implication on clk, off while rst_n is low
`define I8DP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on clk, off while rst_n is low
`define I8DP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/i8dp_pkg.sv -----
// ----------------------------------------------------------------------------
// i8dp_pkg
// Types, register codes and helpers of the int8 dot-product unit.
// ----------------------------------------------------------------------------
package i8dp_pkg;

    localparam int LANES_DEFAULT  = 16;
    localparam int BYTES_PER_WORD = 4;
    localparam int DATA_W         = 32;
    localparam int OFFSET_W       = 9;
    localparam int PROD_W         = 18;

    // Access kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Register map
    localparam logic [3:0] REG_FILTER_BASE = 4'd4;
    localparam logic [3:0] REG_ACC         = 4'd8;

    localparam logic signed [OFFSET_W-1:0] OFFSET_MIN = -9'sd128;
    localparam logic signed [OFFSET_W-1:0] OFFSET_MAX = 9'sd128;

    typedef struct packed {
        logic              kind;
        logic [3:0]        reg_index;
        logic [DATA_W-1:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        logic                     bad_register;
    } out_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic store_input;
        logic store_filter;
        logic acc_clear;
        logic mac_mul;
        logic mac_add;
        logic rsp_load;
        logic rsp_sum;
        logic rsp_bad;
    } dp_cmd_t;

    // Clamp a written offset to the supported range
    function automatic logic signed [OFFSET_W-1:0] sat_offset(
        input logic signed [OFFSET_W-1:0] v
    );
        logic signed [OFFSET_W-1:0] r;
        begin
            r = v;
            if (v < OFFSET_MIN)
            begin
                r = OFFSET_MIN;
            end
            else if (v > OFFSET_MAX)
            begin
                r = OFFSET_MAX;
            end
            return r;
        end
    endfunction

endpackage

// ----- rtl/i8dp_ctrl.sv -----
// ----------------------------------------------------------------------------
// i8dp_ctrl
// Controller: decodes accesses, sequences the lane-by-lane MAC and
// raises the result strobe.
// ----------------------------------------------------------------------------
module i8dp_ctrl #(
    parameter int LANES = i8dp_pkg::LANES_DEFAULT,
    parameter int CW    = $clog2(LANES + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  i8dp_pkg::in_item_t req,
    output logic               busy,
    output logic               done,
    output i8dp_pkg::dp_cmd_t  cmd,
    output logic [CW-1:0]      lane
);
    import i8dp_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_MAC  = 1'b1;

    localparam logic [CW-1:0] LAST_LANE = CW'(LANES);

    logic          state_reg;
    logic          state_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          done_reg;
    logic          done_next;
    logic          accept;

    assign accept = start && (state_reg == ST_IDLE);

    // Decode accesses and step through the lanes
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.kind == KIND_WRITE)
                    begin
                        cmd.rsp_load = 1'b1;
                        if (req.reg_index < REG_FILTER_BASE)
                        begin
                            cmd.store_input = 1'b1;
                        end
                        else if (req.reg_index < REG_ACC)
                        begin
                            cmd.store_filter = 1'b1;
                        end
                        else
                        begin
                            cmd.rsp_bad = 1'b1;
                        end
                    end
                    else if (req.reg_index == REG_ACC)
                    begin
                        cmd.acc_clear = 1'b1;
                        cnt_next      = '0;
                        state_next    = ST_MAC;
                    end
                    else
                    begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_bad  = 1'b1;
                    end
                end
            end
            ST_MAC:
            begin
                cmd.mac_mul = (cnt_reg != LAST_LANE);
                cmd.mac_add = (cnt_reg != '0);
                cnt_next    = cnt_reg + CW'(1);
                if (cnt_reg == LAST_LANE)
                begin
                    cmd.rsp_load = 1'b1;
                    cmd.rsp_sum  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        done_next = cmd.rsp_load;
    end

    // Hold state, lane count and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg == ST_MAC);
    assign done = done_reg;
    assign lane = cnt_reg;

endmodule

// ----- rtl/i8dp_datapath.sv -----
// ----------------------------------------------------------------------------
// i8dp_datapath
// Byte stores, offset register, shared multiplier, accumulator and
// result register.
// ----------------------------------------------------------------------------
module i8dp_datapath #(
    parameter int LANES = i8dp_pkg::LANES_DEFAULT,
    parameter int CW    = $clog2(LANES + 1)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  i8dp_pkg::in_item_t                    req,
    input  i8dp_pkg::dp_cmd_t                     cmd,
    input  logic [CW-1:0]                         lane,
    input  logic                                  cfg_wr,
    input  logic signed [i8dp_pkg::OFFSET_W-1:0]  cfg_data,
    output i8dp_pkg::out_item_t                   rsp
);
    import i8dp_pkg::*;

    localparam int ROWS  = (LANES + BYTES_PER_WORD - 1) / BYTES_PER_WORD;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ACC_W = PROD_W + $clog2(LANES);

    logic [DATA_W-1:0]              in_rows_reg  [ROWS];
    logic [DATA_W-1:0]              flt_rows_reg [ROWS];
    logic signed [OFFSET_W-1:0]     off_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [PROD_W-1:0]       prod_next;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        acc_next;
    out_item_t                      rsp_reg;
    out_item_t                      rsp_next;

    logic                           wr_in_range;
    logic [RW-1:0]                  wr_row;
    logic [RW-1:0]                  rd_row;
    logic [4:0]                     rd_bit;
    logic [DATA_W-1:0]              in_word;
    logic [DATA_W-1:0]              flt_word;
    logic signed [7:0]              in_byte;
    logic signed [7:0]              flt_byte;
    logic signed [OFFSET_W:0]       opnd;

    // Word address of a store write, dropped beyond the last row
    assign wr_in_range = (int'(req.reg_index[1:0]) < ROWS);
    assign wr_row      = RW'(req.reg_index[1:0]);

    // Write the byte stores one word at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                in_rows_reg[r]  <= '0;
                flt_rows_reg[r] <= '0;
            end
        end
        else
        begin
            if (cmd.store_input && wr_in_range)
            begin
                in_rows_reg[wr_row] <= req.write_data;
            end
            if (cmd.store_filter && wr_in_range)
            begin
                flt_rows_reg[wr_row] <= req.write_data;
            end
        end
    end

    // Hold the clamped offset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0;
        end
        else if (cfg_wr)
        begin
            off_reg <= sat_offset(cfg_data);
        end
    end

    // Select the current lane and form its product
    always_comb
    begin
        rd_row    = RW'(lane >> 2);
        rd_bit    = {lane[1:0], 3'b000};
        in_word   = in_rows_reg[rd_row];
        flt_word  = flt_rows_reg[rd_row];
        in_byte   = in_word[rd_bit +: 8];
        flt_byte  = flt_word[rd_bit +: 8];
        opnd      = (OFFSET_W + 1)'(in_byte) + (OFFSET_W + 1)'(off_reg);
        prod_next = opnd * flt_byte;
        acc_next  = acc_reg + ACC_W'(prod_reg);
    end

    // Build the result of the current access
    always_comb
    begin
        rsp_next.read_data    = '0;
        rsp_next.bad_register = cmd.rsp_bad;
        if (cmd.rsp_sum)
        begin
            rsp_next.read_data = DATA_W'(acc_next);
        end
    end

    // Advance the MAC pipeline and load the result
    always_ff @(posedge clk)
    begin
        if (cmd.mac_mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (cmd.mac_add)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ----- rtl/int8_dot_product_unit.sv -----
// ----------------------------------------------------------------------------
// int8_dot_product_unit
// Register-mapped int8 dot-product unit with a configurable input offset.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req and raise start; the access is taken at a
//   rising edge with start high and busy low.
//   Result channel: done is high for one cycle with rsp; the receiver
//   cannot stall, so every result must be taken in that cycle.
//   Configuration: cfg_data is written to the offset register when
//   cfg_valid and cfg_ready are both high; it is clamped to -128..128.
//   Store writes and bad accesses: result in the cycle after acceptance,
//   busy stays low, so one such access may be issued every cycle.
//   Accumulate read: busy while one multiplier walks the lanes (one
//   product per cycle plus one final add), result in the cycle after
//   that; no new access is taken while busy.
//   Reset clears both byte stores, the offset and the controller; the
//   block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module int8_dot_product_unit #(
    parameter int LANES = i8dp_pkg::LANES_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  i8dp_pkg::in_item_t                    req,
    output logic                                  done,
    output i8dp_pkg::out_item_t                   rsp,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic signed [i8dp_pkg::OFFSET_W-1:0]  cfg_data
);
    import i8dp_pkg::*;

    localparam int CW = $clog2(LANES + 1);

    dp_cmd_t       cmd;
    logic [CW-1:0] lane;
    logic          cfg_wr;

    // Take offset writes whenever no read is in flight
    assign cfg_ready = ~busy;
    assign cfg_wr    = cfg_valid && cfg_ready;

    i8dp_ctrl #(
        .LANES (LANES),
        .CW    (CW)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .lane  (lane)
    );

    i8dp_datapath #(
        .LANES (LANES),
        .CW    (CW)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (cmd),
        .lane     (lane),
        .cfg_wr   (cfg_wr),
        .cfg_data (cfg_data),
        .rsp      (rsp)
    );

endmodule

// ----- rtl/i8dp_checker.sv -----
// ----------------------------------------------------------------------------
// i8dp_checker
// Port-level checks of the dot-product unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "int8_dot_product_unit_defines.svh"

module i8dp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input i8dp_pkg::in_item_t  req,
    input logic                done,
    input i8dp_pkg::out_item_t rsp
);
    import i8dp_pkg::*;

    logic acc_read;
    logic take;

    assign acc_read = (req.kind == KIND_READ) && (req.reg_index == REG_ACC);
    assign take     = start && !busy;

    `I8DP_ASSERT_NXT(a_short_done, take && !acc_read, done, "short access gave no result")
    `I8DP_ASSERT_NXT(a_acc_busy, take && acc_read, busy && !done, "accumulate read did not start")
    `I8DP_ASSERT_IMP(a_fell_done, $fell(busy), done, "accumulate ended without a result")
    `I8DP_ASSERT_IMP(a_done_idle, done, !busy, "result shown while busy")
    `I8DP_ASSERT_IMP(a_bad_zero, done && rsp.bad_register, rsp.read_data == '0,
                     "bad access returned nonzero data")

endmodule

bind int8_dot_product_unit i8dp_checker u_i8dp_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
);
